### rtl/gmlos_pkg.sv
package gmlos_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 64;
   localparam int COL_BITS    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_BITS    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_W       = 9;   // holds up to 511
   localparam int CW          = 10;  // signed working coordinate
   localparam int EW          = 12;  // line error term

   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_RECT    = 3'd1,
      OP_DISC    = 3'd2,
      OP_READ    = 3'd3,
      OP_LOS     = 3'd4,
      OP_NEAREST = 3'd5
   } op_type;

   localparam logic [2:0] TYPE_WALKABLE = 3'd0;
   localparam logic [2:0] TYPE_BLOCKED  = 3'd1;
   localparam logic [2:0] TYPE_LAST     = 3'd4;

   localparam logic [0:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] rows;
   } grid_dim_type;

   typedef struct packed {
      logic                  visible;
      logic [2:0]            type_read;
      logic signed [7:0]     found_x;
      logic signed [7:0]     found_y;
   } result_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] addr;
      logic [2:0]           wdata;
   } mem_req_type;

   function automatic logic in_grid(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y,
                                    input grid_dim_type dim);
      logic signed [CW-1:0] c;
      logic signed [CW-1:0] r;
      c = $signed({{(CW-DIM_W){1'b0}}, dim.cols});
      r = $signed({{(CW-DIM_W){1'b0}}, dim.rows});
      return (x >= 0) && (x < c) && (y >= 0) && (y < r);
   endfunction

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic signed [CW-1:0] x,
                                                      input logic signed [CW-1:0] y);
      logic [ADDR_BITS+DIM_W-1:0] a;
      a = ADDR_BITS'(y[ROW_BITS-1:0]) * (ADDR_BITS+DIM_W)'(MAX_COLUMNS)
          + (ADDR_BITS+DIM_W)'(x[COL_BITS-1:0]);
      return a[ADDR_BITS-1:0];
   endfunction

endpackage

### rtl/gmlos_req_if.sv
interface gmlos_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        operation;
   logic signed [7:0] x_a;
   logic signed [7:0] y_a;
   logic signed [7:0] x_b;
   logic signed [7:0] y_b;
   logic [5:0]        radius;
   logic [2:0]        cell_type;

   modport source (output valid, operation, x_a, y_a, x_b, y_b, radius, cell_type,
                   input ready);
   modport sink (input valid, operation, x_a, y_a, x_b, y_b, radius, cell_type,
                 output ready);
endinterface

### rtl/gmlos_rsp_if.sv
interface gmlos_rsp_if;
   logic              valid;
   logic              ready;
   logic              visible;
   logic [2:0]        type_read;
   logic signed [7:0] found_x;
   logic signed [7:0] found_y;

   modport source (output valid, visible, type_read, found_x, found_y, input ready);
   modport sink (input valid, visible, type_read, found_x, found_y, output ready);
endinterface

### rtl/gmlos_csr_if.sv
interface gmlos_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [6:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/gmlos_ram.sv
module gmlos_ram #(
   parameter int Depth = 4096,
   parameter int AddrBits = 12,
   parameter int DataBits = 3
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AddrBits-1:0] addr,
   input  logic [DataBits-1:0] wdata,
   output logic [DataBits-1:0] rdata
);
   logic [DataBits-1:0] mem [Depth];
   logic [DataBits-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/gmlos_seq.sv
module gmlos_seq (
   input  logic                 clock,
   input  logic                 reset,
   gmlos_req_if.sink            req_if,
   input  gmlos_pkg::grid_dim_type  dim,
   output logic                 res_valid,
   input  logic                 res_ready,
   output gmlos_pkg::result_type    res,
   output gmlos_pkg::mem_req_type   mem_req,
   input  logic [2:0]           mem_rdata
);
   import gmlos_pkg::*;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_FILL, S_RD, S_EV, S_DONE} state_type;

   state_type               state_ff;
   logic [ADDR_BITS-1:0]    clr_ff;
   op_type                  op_ff;
   logic [2:0]              ct_ff;
   logic                    disc_ff;
   logic signed [CW-1:0]    bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [CW-1:0]    xlo_ff, xhi_ff, yhi_ff;
   logic signed [CW-1:0]    ex_ff, ey_ff;
   logic signed [EW-1:0]    dx_ff, dy_ff, err_ff;
   logic                    sx_ff, sy_ff;
   logic [5:0]              rad_ff, r_ff;
   logic [11:0]             rr_ff;
   logic                    inb_ff;
   result_type              res_ff;

   logic signed [CW-1:0]    cell_x, cell_y;
   logic                    cell_in;
   logic signed [2*CW-1:0]  sq;
   logic                    walk;
   logic signed [EW-1:0]    e2;
   logic signed [CW-1:0]    r_s;
   logic signed [CW-1:0]    ax, ay, bx_req, by_req;
   logic signed [CW-1:0]    ddx, ddy;

   assign cell_x  = bx_ff + cx_ff;
   assign cell_y  = by_ff + cy_ff;
   assign cell_in = in_grid(cell_x, cell_y, dim);
   assign sq      = cx_ff * cx_ff + cy_ff * cy_ff;
   assign walk    = inb_ff && (mem_rdata != TYPE_BLOCKED);
   assign e2      = err_ff <<< 1;
   assign r_s     = $signed({{(CW-6){1'b0}}, r_ff});
   assign ax      = CW'(req_if.x_a);
   assign ay      = CW'(req_if.y_a);
   assign bx_req  = CW'(req_if.x_b);
   assign by_req  = CW'(req_if.y_b);
   assign ddx     = bx_req - ax;
   assign ddy     = by_req - ay;

   assign req_if.ready = (state_ff == S_IDLE);
   assign res_valid    = (state_ff == S_DONE);
   assign res          = res_ff;

   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.addr  = cell_addr(cell_x, cell_y);
      mem_req.wdata = ct_ff;
      if (state_ff == S_CLEAR) begin
         mem_req.we    = 1'b1;
         mem_req.addr  = clr_ff;
         mem_req.wdata = TYPE_WALKABLE;
      end else if (state_ff == S_FILL) begin
         mem_req.we = cell_in && (!disc_ff || (sq <= $signed({{(2*CW-12){1'b0}}, rr_ff})));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_BITS'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_if.valid) begin
                  op_ff   <= op_type'(req_if.operation);
                  ct_ff   <= req_if.cell_type;
                  rad_ff  <= req_if.radius;
                  rr_ff   <= 12'(req_if.radius) * 12'(req_if.radius);
                  res_ff  <= '0;
                  disc_ff <= (req_if.operation == OP_DISC);
                  bx_ff   <= (req_if.operation == OP_DISC || req_if.operation == OP_NEAREST)
                             ? ax : '0;
                  by_ff   <= (req_if.operation == OP_DISC || req_if.operation == OP_NEAREST)
                             ? ay : '0;
                  ex_ff   <= bx_req;
                  ey_ff   <= by_req;
                  r_ff    <= '0;
                  unique case (req_if.operation)
                     OP_WRITE, OP_RECT: begin
                        cx_ff  <= (req_if.operation == OP_WRITE || ax < bx_req) ? ax : bx_req;
                        cy_ff  <= (req_if.operation == OP_WRITE || ay < by_req) ? ay : by_req;
                        xlo_ff <= (req_if.operation == OP_WRITE || ax < bx_req) ? ax : bx_req;
                        xhi_ff <= (req_if.operation == OP_WRITE || ax >= bx_req) ? ax : bx_req;
                        yhi_ff <= (req_if.operation == OP_WRITE || ay >= by_req) ? ay : by_req;
                        state_ff <= (req_if.cell_type > TYPE_LAST) ? S_DONE : S_FILL;
                     end
                     OP_DISC: begin
                        cx_ff   <= -$signed({{(CW-6){1'b0}}, req_if.radius});
                        cy_ff   <= -$signed({{(CW-6){1'b0}}, req_if.radius});
                        xlo_ff  <= -$signed({{(CW-6){1'b0}}, req_if.radius});
                        xhi_ff  <= $signed({{(CW-6){1'b0}}, req_if.radius});
                        yhi_ff  <= $signed({{(CW-6){1'b0}}, req_if.radius});
                        state_ff <= (req_if.cell_type > TYPE_LAST) ? S_DONE : S_FILL;
                     end
                     OP_READ, OP_LOS: begin
                        cx_ff    <= ax;
                        cy_ff    <= ay;
                        dx_ff    <= EW'(ddx[CW-1] ? -ddx : ddx);
                        dy_ff    <= EW'(ddy[CW-1] ? -ddy : ddy);
                        err_ff   <= EW'(ddx[CW-1] ? -ddx : ddx) - EW'(ddy[CW-1] ? -ddy : ddy);
                        sx_ff    <= (ax < bx_req);
                        sy_ff    <= (ay < by_req);
                        state_ff <= S_RD;
                     end
                     OP_NEAREST: begin
                        cx_ff    <= '0;
                        cy_ff    <= '0;
                        state_ff <= S_RD;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_FILL: begin
               if (cx_ff == xhi_ff) begin
                  cx_ff <= xlo_ff;
                  if (cy_ff == yhi_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     cy_ff <= cy_ff + 1'b1;
                  end
               end else begin
                  cx_ff <= cx_ff + 1'b1;
               end
            end
            S_RD: begin
               inb_ff   <= cell_in;
               state_ff <= S_EV;
            end
            S_EV: begin
               unique case (op_ff)
                  OP_READ: begin
                     res_ff.type_read <= inb_ff ? mem_rdata : TYPE_BLOCKED;
                     state_ff <= S_DONE;
                  end
                  OP_LOS: begin
                     if (!walk) begin
                        state_ff <= S_DONE;
                     end else if (cx_ff == ex_ff && cy_ff == ey_ff) begin
                        res_ff.visible <= 1'b1;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_RD;
                        if (e2 > -dy_ff && e2 < dx_ff) begin
                           err_ff <= err_ff - dy_ff + dx_ff;
                        end else if (e2 > -dy_ff) begin
                           err_ff <= err_ff - dy_ff;
                        end else if (e2 < dx_ff) begin
                           err_ff <= err_ff + dx_ff;
                        end
                        if (e2 > -dy_ff) begin
                           cx_ff <= sx_ff ? cx_ff + 1'b1 : cx_ff - 1'b1;
                        end
                        if (e2 < dx_ff) begin
                           cy_ff <= sy_ff ? cy_ff + 1'b1 : cy_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     // ring walk: top and bottom rows in full, sides at both ends
                     if (walk) begin
                        res_ff.found_x <= cell_x[7:0];
                        res_ff.found_y <= cell_y[7:0];
                        state_ff <= S_DONE;
                     end else if ((r_ff == '0 && rad_ff == '0)
                                  || (r_ff == rad_ff && cx_ff == r_s && cy_ff == r_s)) begin
                        res_ff.found_x <= bx_ff[7:0];
                        res_ff.found_y <= by_ff[7:0];
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_RD;
                        if (r_ff == '0) begin
                           r_ff  <= 6'd1;
                           cx_ff <= -CW'(1);
                           cy_ff <= -CW'(1);
                        end else if (cx_ff == r_s) begin
                           if (cy_ff == r_s) begin
                              r_ff  <= r_ff + 1'b1;
                              cx_ff <= -(r_s + 1'b1);
                              cy_ff <= -(r_s + 1'b1);
                           end else begin
                              cy_ff <= cy_ff + 1'b1;
                              cx_ff <= -r_s;
                           end
                        end else if (cy_ff == r_s || cy_ff == -r_s) begin
                           cx_ff <= cx_ff + 1'b1;
                        end else begin
                           cx_ff <= r_s;
                        end
                     end
                  end
               endcase
            end
            S_DONE: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### rtl/grid_map_line_of_sight.sv
// Grid map of up to 64 by 64 cell types held in one single-port synchronous RAM, with
// cell write, rectangle and disc fill, cell read, Bresenham line of sight and a
// nearest-walkable ring search. After reset the block clears all 4096 cells of the map
// to walkable and accepts no word meanwhile; configuration writes are always taken.
// Each word then runs alone: a write or fill handles one cell of its bounding box per
// cycle, while a read, line of sight or ring search visits its cells one at a time,
// each by a RAM read then a test; a search visits up to (2r+1)^2 cells. A finished
// result waits in an output register while the next word is taken.
module grid_map_line_of_sight (
   input logic        clock,
   input logic        reset,
   gmlos_req_if.sink  req_if,
   gmlos_rsp_if.source rsp_if,
   gmlos_csr_if.sink  csr_if
);
   import gmlos_pkg::*;

   logic [6:0]   grid_width_ff, grid_height_ff;
   grid_dim_type dim;
   logic         rsp_valid_ff;
   result_type   rsp_word_ff;
   logic         res_valid, res_ready;
   result_type   res;
   mem_req_type  mem_req;
   logic [2:0]   mem_rdata;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 7'd64;
         grid_height_ff <= 7'd64;
      end else if (csr_if.valid) begin
         if (csr_if.index == CSR_GRID_WIDTH) begin
            grid_width_ff <= csr_if.data;
         end
         if (csr_if.index == CSR_GRID_HEIGHT) begin
            grid_height_ff <= csr_if.data;
         end
      end
   end

   assign dim.cols = (DIM_W'(grid_width_ff) > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS)
                                                                  : DIM_W'(grid_width_ff);
   assign dim.rows = (DIM_W'(grid_height_ff) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                                 : DIM_W'(grid_height_ff);

   gmlos_ram #(.Depth(DEPTH), .AddrBits(ADDR_BITS), .DataBits(3)) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   gmlos_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .dim       (dim),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.visible   = rsp_word_ff.visible;
   assign rsp_if.type_read = rsp_word_ff.type_read;
   assign rsp_if.found_x   = rsp_word_ff.found_x;
   assign rsp_if.found_y   = rsp_word_ff.found_y;
endmodule

### tb/sv/tb_grid_map_line_of_sight.sv
`timescale 1ns / 100ps

module tb_grid_map_line_of_sight;
   import gmlos_pkg::*;

   localparam logic [2:0] OP_SPARE_LO    = 3'd6;
   localparam logic [2:0] OP_SPARE_HI    = 3'd7;
   localparam logic [2:0] TYPE_DIFFICULT = 3'd2;
   localparam logic [2:0] TYPE_WATER     = 3'd3;
   localparam logic [2:0] TYPE_HAZARD    = 3'd4;
   localparam logic [2:0] TYPE_BAD       = 3'd7;

   typedef struct {
      logic [2:0]        operation;
      logic signed [7:0] x_a;
      logic signed [7:0] y_a;
      logic signed [7:0] x_b;
      logic signed [7:0] y_b;
      logic [5:0]        radius;
      logic [2:0]        cell_type;
   } grid_cmd_type;

   logic clock;
   logic reset;

   gmlos_req_if req_bus ();
   gmlos_rsp_if rsp_bus ();
   gmlos_csr_if csr_bus ();

   grid_map_line_of_sight uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // shadow copy of the block's map and registers
   logic [2:0] shadow_map [MAX_ROWS][MAX_COLUMNS];
   logic [6:0] shadow_width;
   logic [6:0] shadow_height;
   result_type expected_results [$];
   int         error_count;
   int         stall_percent;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int cols_used();
      return (shadow_width > MAX_COLUMNS) ? MAX_COLUMNS : int'(shadow_width);
   endfunction

   function automatic int rows_used();
      return (shadow_height > MAX_ROWS) ? MAX_ROWS : int'(shadow_height);
   endfunction

   function automatic bit cell_in_grid(int x, int y);
      return x >= 0 && x < cols_used() && y >= 0 && y < rows_used();
   endfunction

   function automatic logic [2:0] cell_type_at(int x, int y);
      if (!cell_in_grid(x, y)) return TYPE_BLOCKED;
      return shadow_map[y][x];
   endfunction

   function automatic bit cell_walkable(int x, int y);
      return cell_type_at(x, y) != TYPE_BLOCKED;
   endfunction

   function automatic void store_cell(int x, int y, logic [2:0] t);
      if (cell_in_grid(x, y) && t <= TYPE_LAST) shadow_map[y][x] = t;
   endfunction

   function automatic bit sight_clear(int x0, int y0, int x1, int y1);
      int dx, dy, sx, sy, err, e2;
      dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx  = (x0 < x1) ? 1 : -1;
      sy  = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      forever begin
         if (!cell_walkable(x0, y0)) return 1'b0;
         if (x0 == x1 && y0 == y1) return 1'b1;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            x0 += sx;
         end
         if (e2 < dx) begin
            err += dx;
            y0 += sy;
         end
      end
   endfunction

   // applies one command to the shadow map and gives the result it should produce
   function automatic result_type grid_outcome(grid_cmd_type c);
      result_type res;
      int xa, ya, xb, yb, rad, fx, fy;
      bit found;
      xa  = c.x_a;
      ya  = c.y_a;
      xb  = c.x_b;
      yb  = c.y_b;
      rad = c.radius;
      res = '0;
      case (c.operation)
         OP_WRITE: store_cell(xa, ya, c.cell_type);
         OP_RECT: begin
            for (int y = (ya < yb ? ya : yb); y <= (ya < yb ? yb : ya); y++)
               for (int x = (xa < xb ? xa : xb); x <= (xa < xb ? xb : xa); x++)
                  store_cell(x, y, c.cell_type);
         end
         OP_DISC: begin
            for (int y = -rad; y <= rad; y++)
               for (int x = -rad; x <= rad; x++)
                  if (x * x + y * y <= rad * rad) store_cell(xa + x, ya + y, c.cell_type);
         end
         OP_READ: res.type_read = cell_type_at(xa, ya);
         OP_LOS: res.visible = sight_clear(xa, ya, xb, yb);
         OP_NEAREST: begin
            fx = xa;
            fy = ya;
            found = cell_walkable(xa, ya);
            for (int r = 1; r <= rad && !found; r++)
               for (int y = -r; y <= r && !found; y++)
                  for (int x = -r; x <= r && !found; x++)
                     if ((x == r || x == -r || y == r || y == -r)
                         && cell_walkable(xa + x, ya + y)) begin
                        fx = xa + x;
                        fy = ya + y;
                        found = 1'b1;
                     end
            res.found_x = fx[7:0];
            res.found_y = fy[7:0];
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word, visible", rsp_bus.visible, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.visible !== want.visible)
               report_mismatch("visible", rsp_bus.visible, want.visible);
            if (rsp_bus.type_read !== want.type_read)
               report_mismatch("type_read", rsp_bus.type_read, want.type_read);
            if (rsp_bus.found_x !== want.found_x)
               report_mismatch("found_x", rsp_bus.found_x, want.found_x);
            if (rsp_bus.found_y !== want.found_y)
               report_mismatch("found_y", rsp_bus.found_y, want.found_y);
         end
      end
   end

   // receiver stalls on its own pattern
   always @(negedge clock) begin
      if (reset) rsp_bus.ready = 1'b0;
      else rsp_bus.ready = ($urandom_range(99) >= stall_percent);
   end

   task automatic send_cmd(grid_cmd_type c);
      @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.operation = c.operation;
      req_bus.x_a       = c.x_a;
      req_bus.y_a       = c.y_a;
      req_bus.x_b       = c.x_b;
      req_bus.y_b       = c.y_b;
      req_bus.radius    = c.radius;
      req_bus.cell_type = c.cell_type;
      do @(posedge clock); while (!req_bus.ready);
      expected_results = {expected_results, grid_outcome(c)};
   endtask

   task automatic idle_gap(int cycles);
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      idle_gap(1);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [6:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_GRID_WIDTH) shadow_width = value;
      else shadow_height = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_grid(logic [6:0] w, logic [6:0] h);
      drain_results();
      write_csr(CSR_GRID_WIDTH, w);
      write_csr(CSR_GRID_HEIGHT, h);
   endtask

   function automatic grid_cmd_type make_cmd(logic [2:0] op, int xa, int ya, int xb, int yb,
                                             int rad, logic [2:0] t);
      grid_cmd_type c;
      c.operation = op;
      c.x_a = xa[7:0];
      c.y_a = ya[7:0];
      c.x_b = xb[7:0];
      c.y_b = yb[7:0];
      c.radius = rad[5:0];
      c.cell_type = t;
      return c;
   endfunction

   // mostly near the grid in use, now and then anywhere
   function automatic int pick_coord(int span);
      if ($urandom_range(99) < 88) return int'($urandom_range(span + 3)) - 2;
      return int'($signed(8'($urandom)));
   endfunction

   function automatic logic [2:0] pick_type();
      int p;
      p = $urandom_range(99);
      if (p < 35) return TYPE_BLOCKED;
      if (p < 65) return TYPE_WALKABLE;
      if (p < 95) return 3'($urandom_range(TYPE_LAST));
      return 3'($urandom_range(7, 5));
   endfunction

   function automatic grid_cmd_type random_cmd();
      grid_cmd_type c;
      int p, xa, ya;
      p = $urandom_range(99);
      c = make_cmd(3'($urandom), $urandom, $urandom, $urandom, $urandom,
                   $urandom, pick_type());
      xa = pick_coord(cols_used());
      ya = pick_coord(rows_used());
      c.x_a = xa[7:0];
      c.y_a = ya[7:0];
      if (p < 15) c.operation = OP_WRITE;
      else if (p < 25) begin
         c.operation = OP_RECT;
         if ($urandom_range(99) < 97) begin
            c.x_b = 8'(xa + int'($urandom_range(16)) - 8);
            c.y_b = 8'(ya + int'($urandom_range(16)) - 8);
         end
      end else if (p < 33) begin
         c.operation = OP_DISC;
         if ($urandom_range(99) < 95) c.radius = 6'($urandom_range(6));
      end else if (p < 55) c.operation = OP_READ;
      else if (p < 80) begin
         c.operation = OP_LOS;
         if ($urandom_range(99) < 90) begin
            c.x_b = 8'(pick_coord(cols_used()));
            c.y_b = 8'(pick_coord(rows_used()));
         end
      end else if (p < 95) begin
         c.operation = OP_NEAREST;
         if ($urandom_range(99) < 95) c.radius = 6'($urandom_range(6));
      end else c.operation = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
      return c;
   endfunction

   task automatic test_random(int count);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(30, 1);
         stall_percent = ($urandom_range(3) == 0) ? 0 : $urandom_range(70);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_cmd(random_cmd());
            sent++;
         end
         if ($urandom_range(3) != 0) idle_gap($urandom_range(6, 1));
      end
   endtask

   task automatic test_basic_ops();
      stall_percent = 30;
      send_cmd(make_cmd(OP_WRITE, 0, 0, 0, 0, 0, TYPE_HAZARD));
      send_cmd(make_cmd(OP_WRITE, 63, 63, 0, 0, 0, TYPE_WATER));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_READ, 63, 63, 0, 0, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_RECT, 20, 14, 10, 10, 0, TYPE_BLOCKED));
      send_cmd(make_cmd(OP_DISC, 40, 40, 0, 0, 3, TYPE_DIFFICULT));
      send_cmd(make_cmd(OP_DISC, 5, 50, 0, 0, 0, TYPE_BLOCKED));
      send_cmd(make_cmd(OP_READ, 5, 50, 0, 0, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_LOS, 0, 12, 30, 12, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_LOS, 0, 30, 40, 2, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_LOS, 33, 33, 33, 33, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_NEAREST, 15, 12, 0, 0, 4, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_NEAREST, 15, 12, 0, 0, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_NEAREST, 30, 30, 0, 0, 2, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_SPARE_LO, 1, 1, 1, 1, 1, TYPE_BLOCKED));
      send_cmd(make_cmd(OP_SPARE_HI, -1, -1, -1, -1, 63, TYPE_BAD));
   endtask

   task automatic test_bounds();
      stall_percent = 0;
      // out of range writes and unknown types leave the map alone
      send_cmd(make_cmd(OP_WRITE, -1, 0, 0, 0, 0, TYPE_HAZARD));
      send_cmd(make_cmd(OP_WRITE, 64, 5, 0, 0, 0, TYPE_HAZARD));
      send_cmd(make_cmd(OP_WRITE, 2, 2, 0, 0, 0, TYPE_BAD));
      send_cmd(make_cmd(OP_READ, 2, 2, 0, 0, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_READ, -128, 127, 0, 0, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_RECT, 60, -3, 70, 2, 0, TYPE_HAZARD));
      send_cmd(make_cmd(OP_DISC, 0, 63, 0, 0, 5, TYPE_WATER));
      send_cmd(make_cmd(OP_LOS, 60, 60, 64, 60, 0, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_NEAREST, -5, -5, 0, 0, 7, TYPE_WALKABLE));
      send_cmd(make_cmd(OP_NEAREST, 127, -128, 0, 0, 2, TYPE_WALKABLE));
   endtask

   initial begin
      error_count   = 0;
      stall_percent = 0;
      shadow_width  = 7'd64;
      shadow_height = 7'd64;
      foreach (shadow_map[y, x]) shadow_map[y][x] = TYPE_WALKABLE;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_WRITE;
      req_bus.x_a = '0;
      req_bus.y_a = '0;
      req_bus.x_b = '0;
      req_bus.y_b = '0;
      req_bus.radius = '0;
      req_bus.cell_type = TYPE_WALKABLE;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_GRID_WIDTH;
      csr_bus.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_bounds();
      test_random(550);
      set_grid(7'd1, 7'd1);
      test_random(100);
      set_grid(7'd0, 7'd64);
      test_random(60);
      set_grid(7'd64, 7'd0);
      test_random(40);
      set_grid(7'd127, 7'd127);
      test_random(400);
      set_grid(7'd23, 7'd11);
      test_random(400);
      set_grid(7'd64, 7'd64);
      test_random(180);

      drain_results();
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
